### rtl/core/lfu_pkg.sv
// Shared constants, types and sequencer states of the frequency table.
package lfu_pkg;

  localparam int NUM_GROUPS  = 16;
  localparam int CAPACITY    = 64;
  localparam int LEVELS      = 256;

  localparam int GROUP_W     = 8;
  localparam int KEY_W       = 64;
  localparam int CNT_W       = 8;
  localparam int LIM_W       = 7;
  localparam int LIMIT_RESET = 64;

  localparam int GRP_W  = $clog2(NUM_GROUPS);
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int ENT_AW = GRP_W + SLOT_W;
  localparam int LL_AW  = GRP_W + LVL_W;
  localparam int ENT_D  = NUM_GROUPS * CAPACITY;
  localparam int LL_D   = NUM_GROUPS * LEVELS;
  localparam int SCAN_W = ((LVL_W > SLOT_W) ? LVL_W : SLOT_W) + 1;
  localparam int CLR_N  = (LL_D > ENT_D) ? LL_D : ENT_D;
  localparam int CLR_W  = $clog2(CLR_N + 1);

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [LVL_W-1:0]  level;
    logic [SLOT_W-1:0] pos;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] new_count;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic             dropped;
  } result_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_LL_RD,
    S_LL_CAP,
    S_SCAN1,
    S_DECIDE,
    S_H_RD,
    S_H_CAP,
    S_SCAN2,
    S_H_WM,
    S_H_DEC,
    S_H_ART,
    S_H_ACAP,
    S_LSCAN,
    S_EVICT,
    S_N_RD,
    S_N_CAP,
    S_DONE
  } state_t;

endpackage

### rtl/core/lfu_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module lfu_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/lfu_seq.sv
// Sequencer that walks the entry and level-length memories for each item.
module lfu_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic [lfu_pkg::GROUP_W-1:0]   in_group,
  input  logic [lfu_pkg::KEY_W-1:0]     in_key,
  input  logic [lfu_pkg::LIM_W-1:0]     limit,
  output logic                          ready,
  output logic                          res_valid,
  input  logic                          res_take,
  output lfu_pkg::result_t              res
);
  import lfu_pkg::*;

  localparam logic [SCAN_W-1:0] CAP_S   = SCAN_W'(CAPACITY);
  localparam logic [SCAN_W-1:0] LVL_S   = SCAN_W'(LEVELS);
  localparam logic [LVL_W-1:0]  LVL_MAX = LVL_W'(LEVELS - 1);
  localparam logic [LVL_W-1:0]  LVL_ONE = LVL_W'(1);
  localparam logic [LEN_W-1:0]  LEN_ONE = LEN_W'(1);

  state_t state_r, state_nxt;

  logic [CLR_W-1:0]    clr_r;
  logic [SCAN_W-1:0]   cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [SCAN_W-2:0]   pidx_r, pidx_nxt;
  logic [LVL_W-1:0]    lowest_r [NUM_GROUPS];
  logic [LEN_W-1:0]    occ_r    [NUM_GROUPS];

  logic [GRP_W-1:0]    grp_r, grp_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic                found_r, found_nxt;
  logic [SLOT_W-1:0]   f_idx_r, f_idx_nxt;
  entry_t              f_ent_r, f_ent_nxt;
  logic                free_r, free_nxt;
  logic [SLOT_W-1:0]   free_idx_r, free_idx_nxt;
  logic                vic_r, vic_nxt;
  logic [SLOT_W-1:0]   vic_idx_r, vic_idx_nxt;
  logic [KEY_W-1:0]    vic_key_r, vic_key_nxt;
  logic                m_r, m_nxt;
  logic [SLOT_W-1:0]   m_idx_r, m_idx_nxt;
  entry_t              m_ent_r, m_ent_nxt;
  logic                lfound_r, lfound_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    lo_len_r, lo_len_nxt;
  result_t             res_r, res_nxt;

  logic                ent_we;
  logic [ENT_AW-1:0]   ent_wa, ent_ra;
  entry_t              ent_wd, ent_rd;
  logic                ll_we;
  logic [LL_AW-1:0]    ll_wa, ll_ra;
  logic [LEN_W-1:0]    ll_wd, ll_rd;
  logic                low_we, occ_we;
  logic [LVL_W-1:0]    low_wd;
  logic [LEN_W-1:0]    occ_wd;

  logic [LVL_W-1:0]    cur_low, nl;
  logic [LEN_W-1:0]    cur_occ, lim_eff;
  logic [SLOT_W-1:0]   sidx;

  lfu_ram #(.W(ENT_W), .D(ENT_D)) u_ent (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_wa),
    .wdata (ent_wd),
    .raddr (ent_ra),
    .rdata (ent_rd)
  );

  lfu_ram #(.W(LEN_W), .D(LL_D)) u_len (
    .clk   (clk),
    .we    (ll_we),
    .waddr (ll_wa),
    .wdata (ll_wd),
    .raddr (ll_ra),
    .rdata (ll_rd)
  );

  assign cur_low = lowest_r[grp_r];
  assign cur_occ = occ_r[grp_r];
  assign nl      = (f_ent_r.level == LVL_MAX) ? LVL_MAX : f_ent_r.level + LVL_ONE;
  assign sidx    = pidx_r[SLOT_W-1:0];

  always_comb begin
    if (limit == '0) begin
      lim_eff = LEN_ONE;
    end else if (32'(limit) > CAPACITY) begin
      lim_eff = LEN_W'(CAPACITY);
    end else begin
      lim_eff = LEN_W'(limit);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = 1'b0;
    pidx_nxt     = pidx_r;
    grp_nxt      = grp_r;
    key_nxt      = key_r;
    found_nxt    = found_r;
    f_idx_nxt    = f_idx_r;
    f_ent_nxt    = f_ent_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    vic_nxt      = vic_r;
    vic_idx_nxt  = vic_idx_r;
    vic_key_nxt  = vic_key_r;
    m_nxt        = m_r;
    m_idx_nxt    = m_idx_r;
    m_ent_nxt    = m_ent_r;
    lfound_nxt   = lfound_r;
    len_nxt      = len_r;
    lo_len_nxt   = lo_len_r;
    res_nxt      = res_r;
    ent_we       = 1'b0;
    ent_wa       = {grp_r, f_idx_r};
    ent_wd       = '0;
    ent_ra       = {grp_r, cnt_r[SLOT_W-1:0]};
    ll_we        = 1'b0;
    ll_wa        = {grp_r, cur_low};
    ll_wd        = '0;
    ll_ra        = {grp_r, cur_low};
    low_we       = 1'b0;
    low_wd       = LVL_ONE;
    occ_we       = 1'b0;
    occ_wd       = cur_occ;
    ready        = 1'b0;
    res_valid    = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ent_we = (32'(clr_r) < ENT_D);
        ent_wa = clr_r[ENT_AW-1:0];
        ll_we  = (32'(clr_r) < LL_D);
        ll_wa  = clr_r[LL_AW-1:0];
        if (32'(clr_r) == CLR_N - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ready = 1'b1;
        if (in_fire) begin
          grp_nxt   = in_group[GRP_W-1:0];
          key_nxt   = in_key;
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          vic_nxt   = 1'b0;
          res_nxt   = '0;
          if (32'(in_group) >= NUM_GROUPS) begin
            res_nxt.dropped = 1'b1;
            state_nxt       = S_DONE;
          end else begin
            state_nxt = S_LL_RD;
          end
        end
      end
      S_LL_RD: begin
        state_nxt = S_LL_CAP;
      end
      S_LL_CAP: begin
        lo_len_nxt = ll_rd;
        cnt_nxt    = '0;
        state_nxt  = S_SCAN1;
      end
      S_SCAN1: begin
        // One pass finds the key, the first free slot and the eviction victim.
        if (pend_r) begin
          if (ent_rd.valid && ent_rd.key == key_r && !found_r) begin
            found_nxt = 1'b1;
            f_idx_nxt = sidx;
            f_ent_nxt = ent_rd;
          end
          if (!ent_rd.valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = sidx;
          end
          if (ent_rd.valid && ent_rd.level == cur_low && lo_len_r != '0 &&
              LEN_W'(ent_rd.pos) == lo_len_r - LEN_ONE && !vic_r) begin
            vic_nxt     = 1'b1;
            vic_idx_nxt = sidx;
            vic_key_nxt = ent_rd.key;
          end
        end
        if (cnt_r < CAP_S) begin
          cnt_nxt  = cnt_r + 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = cnt_r[SCAN_W-2:0];
        end else if (!pend_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (found_r) begin
          state_nxt = S_H_RD;
        end else if (cur_occ >= lim_eff && vic_r) begin
          state_nxt = S_EVICT;
        end else begin
          state_nxt = S_N_RD;
        end
      end
      S_H_RD: begin
        ll_ra     = {grp_r, f_ent_r.level};
        state_nxt = S_H_CAP;
      end
      S_H_CAP: begin
        len_nxt = ll_rd;
        cnt_nxt = '0;
        m_nxt   = 1'b0;
        if (ll_rd == '0) begin
          state_nxt = S_H_ART;
        end else if (LEN_W'(f_ent_r.pos) != ll_rd - LEN_ONE) begin
          state_nxt = S_SCAN2;
        end else begin
          state_nxt = S_H_DEC;
        end
      end
      S_SCAN2: begin
        // Look for the last member of the old level, which fills the hole.
        if (pend_r && ent_rd.valid && ent_rd.level == f_ent_r.level &&
            LEN_W'(ent_rd.pos) == len_r - LEN_ONE && !m_r) begin
          m_nxt     = 1'b1;
          m_idx_nxt = sidx;
          m_ent_nxt = ent_rd;
        end
        if (cnt_r < CAP_S) begin
          cnt_nxt  = cnt_r + 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = cnt_r[SCAN_W-2:0];
        end else if (!pend_r) begin
          state_nxt = m_r ? S_H_WM : S_H_DEC;
        end
      end
      S_H_WM: begin
        ent_we     = 1'b1;
        ent_wa     = {grp_r, m_idx_r};
        ent_wd     = m_ent_r;
        ent_wd.pos = f_ent_r.pos;
        state_nxt  = S_H_DEC;
      end
      S_H_DEC: begin
        ll_we     = 1'b1;
        ll_wa     = {grp_r, f_ent_r.level};
        ll_wd     = len_r - LEN_ONE;
        state_nxt = S_H_ART;
      end
      S_H_ART: begin
        ll_ra     = {grp_r, nl};
        state_nxt = S_H_ACAP;
      end
      S_H_ACAP: begin
        ent_we       = 1'b1;
        ent_wd.valid = 1'b1;
        ent_wd.key   = key_r;
        ent_wd.level = nl;
        ent_wd.pos   = ll_rd[SLOT_W-1:0];
        ll_we        = 1'b1;
        ll_wa        = {grp_r, nl};
        ll_wd        = ll_rd + LEN_ONE;
        res_nxt.hit       = 1'b1;
        res_nxt.new_count = CNT_W'(nl);
        if (f_ent_r.level == cur_low) begin
          cnt_nxt    = SCAN_W'(f_ent_r.level);
          lfound_nxt = 1'b0;
          state_nxt  = S_LSCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LSCAN: begin
        ll_ra = {grp_r, cnt_r[LVL_W-1:0]};
        if (pend_r && ll_rd != '0 && !lfound_r) begin
          lfound_nxt = 1'b1;
          low_we     = 1'b1;
          low_wd     = pidx_r[LVL_W-1:0];
        end
        if (cnt_r < LVL_S) begin
          cnt_nxt  = cnt_r + 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = cnt_r[SCAN_W-2:0];
        end else if (!pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_EVICT: begin
        ent_we = 1'b1;
        ent_wa = {grp_r, vic_idx_r};
        ll_we  = 1'b1;
        ll_wd  = lo_len_r - LEN_ONE;
        occ_we = 1'b1;
        occ_wd = cur_occ - LEN_ONE;
        res_nxt.evicted     = 1'b1;
        res_nxt.evicted_key = vic_key_r;
        // The victim's slot is free now and may come first.
        if (!free_r || vic_idx_r < free_idx_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = vic_idx_r;
        end
        state_nxt = S_N_RD;
      end
      S_N_RD: begin
        ll_ra     = {grp_r, LVL_ONE};
        state_nxt = S_N_CAP;
      end
      S_N_CAP: begin
        if (free_r) begin
          ent_we       = 1'b1;
          ent_wa       = {grp_r, free_idx_r};
          ent_wd.valid = 1'b1;
          ent_wd.key   = key_r;
          ent_wd.level = LVL_ONE;
          ent_wd.pos   = ll_rd[SLOT_W-1:0];
          ll_we        = 1'b1;
          ll_wa        = {grp_r, LVL_ONE};
          ll_wd        = ll_rd + LEN_ONE;
          occ_we       = 1'b1;
          occ_wd       = cur_occ + LEN_ONE;
          low_we       = 1'b1;
          res_nxt.new_count = CNT_W'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      pend_r  <= 1'b0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        lowest_r[i] <= LVL_ONE;
        occ_r[i]    <= '0;
      end
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (low_we) begin
        lowest_r[grp_r] <= low_wd;
      end
      if (occ_we) begin
        occ_r[grp_r] <= occ_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    pidx_r     <= pidx_nxt;
    grp_r      <= grp_nxt;
    key_r      <= key_nxt;
    found_r    <= found_nxt;
    f_idx_r    <= f_idx_nxt;
    f_ent_r    <= f_ent_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    vic_r      <= vic_nxt;
    vic_idx_r  <= vic_idx_nxt;
    vic_key_r  <= vic_key_nxt;
    m_r        <= m_nxt;
    m_idx_r    <= m_idx_nxt;
    m_ent_r    <= m_ent_nxt;
    lfound_r   <= lfound_nxt;
    len_r      <= len_nxt;
    lo_len_r   <= lo_len_nxt;
    res_r      <= res_nxt;
  end

endmodule

### rtl/core/lfu_frequency_table.sv
// Top level of the per-group key frequency table with its output register.
//
//  Channel   Direction  Handshake           Beat carries
//  in_       input      in_valid/in_stall   group, item_key
//  out_      output     out_valid/out_stall hit, new_count, evicted, evicted_key, dropped
//  cfg_      input      cfg_valid/cfg_ready occupancy_limit
//
// After reset a clearing pass empties both memories; no beat is taken then.
// A dropped beat goes straight to the result; a new key waits on the 64-slot entry scan,
// and an eviction adds a write step before the insertion.
// A hit runs up to two entry scans and a scan of up to 256 levels.
// One item is in work at a time; the result waits in the output register under out_stall.
module lfu_frequency_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lfu_pkg::GROUP_W-1:0] in_group,
  input  logic [lfu_pkg::KEY_W-1:0]   in_item_key,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic [lfu_pkg::CNT_W-1:0]   out_new_count,
  output logic                        out_evicted,
  output logic [lfu_pkg::KEY_W-1:0]   out_evicted_key,
  output logic                        out_dropped,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lfu_pkg::LIM_W-1:0]   cfg_occupancy_limit
);
  import lfu_pkg::*;

  logic             seq_ready, res_valid, res_take;
  result_t          res, out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LIM_W-1:0] limit_r;

  lfu_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_valid && seq_ready),
    .in_group  (in_group),
    .in_key    (in_item_key),
    .limit     (limit_r),
    .ready     (seq_ready),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign in_stall  = !seq_ready;
  assign cfg_ready = 1'b1;
  assign res_take  = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      limit_r     <= LIM_W'(LIMIT_RESET);
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_occupancy_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_r.hit;
  assign out_new_count   = out_r.new_count;
  assign out_evicted     = out_r.evicted;
  assign out_evicted_key = out_r.evicted_key;
  assign out_dropped     = out_r.dropped;

  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> !out_hit && !out_evicted && out_new_count == '0)
    else $error("dropped beat carries a result");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit && out_new_count == CNT_W'(1))
    else $error("eviction without a fresh insertion");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_new_count != '0)
    else $error("hit with zero count");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

endmodule

### tb/lfu_frequency_table_tb.sv
// Self-checking testbench for the per-group key frequency table.
`timescale 1ns / 100ps

module lfu_frequency_table_tb;
  import lfu_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int IDLE_GAP       = 450;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [GROUP_W-1:0]   in_group;
  logic [KEY_W-1:0]     in_item_key;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_hit;
  logic [CNT_W-1:0]     out_new_count;
  logic                 out_evicted;
  logic [KEY_W-1:0]     out_evicted_key;
  logic                 out_dropped;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LIM_W-1:0]     cfg_occupancy_limit;

  lfu_frequency_table u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_group            (in_group),
    .in_item_key         (in_item_key),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hit             (out_hit),
    .out_new_count       (out_new_count),
    .out_evicted         (out_evicted),
    .out_evicted_key     (out_evicted_key),
    .out_dropped         (out_dropped),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_occupancy_limit (cfg_occupancy_limit)
  );

  // Shadow copy of the frequency tables.
  logic [KEY_W-1:0] sh_key   [NUM_GROUPS][CAPACITY];
  bit               sh_valid [NUM_GROUPS][CAPACITY];
  int               sh_level [NUM_GROUPS][CAPACITY];
  int               sh_pos   [NUM_GROUPS][CAPACITY];
  int               sh_len   [NUM_GROUPS][LEVELS];
  int               sh_lowest[NUM_GROUPS];
  int               sh_occ   [NUM_GROUPS];
  int               sh_limit;

  result_t expected_counts[$];
  int      fail_count;
  int      sender_idle_pct;
  int      receiver_stall_pct;
  bit      receiver_hold;
  int      quiet_cycles;

  typedef struct {
    logic [GROUP_W-1:0] grp;
    logic [KEY_W-1:0]   k;
    bit                 typed;
    result_t            res;
  } stim_row_t;

  function automatic int member_of(int g, int lvl, int p);
    for (int s = 0; s < CAPACITY; s++)
      if (sh_valid[g][s] && sh_level[g][s] == lvl && sh_pos[g][s] == p) return s;
    return -1;
  endfunction

  function automatic void unlink_entry(int g, int s);
    int lvl;
    int p;
    int len;
    int m;
    lvl = sh_level[g][s];
    p   = sh_pos[g][s];
    len = sh_len[g][lvl];
    if (len == 0) return;
    if (p != len - 1) begin
      m = member_of(g, lvl, len - 1);
      if (m >= 0) sh_pos[g][m] = p;
    end
    sh_len[g][lvl] = len - 1;
  endfunction

  function automatic void link_entry(int g, int s, int lvl);
    sh_level[g][s] = lvl;
    sh_pos[g][s]   = sh_len[g][lvl];
    sh_len[g][lvl]++;
  endfunction

  function automatic result_t count_item(logic [GROUP_W-1:0] grp, logic [KEY_W-1:0] k);
    result_t r;
    int g;
    int found;
    int old;
    int nl;
    int lim;
    int lo;
    int len;
    int v;
    int fr;
    r = '0;
    g = grp;
    if (g >= NUM_GROUPS) begin
      r.dropped = 1'b1;
      return r;
    end
    found = -1;
    for (int s = 0; s < CAPACITY; s++)
      if (found < 0 && sh_valid[g][s] && sh_key[g][s] == k) found = s;
    if (found >= 0) begin
      old = sh_level[g][found];
      nl  = (old < LEVELS - 1) ? old + 1 : LEVELS - 1;
      unlink_entry(g, found);
      link_entry(g, found, nl);
      if (old == sh_lowest[g]) begin
        for (int l = LEVELS - 1; l >= old; l--)
          if (sh_len[g][l] != 0) sh_lowest[g] = l;
      end
      r.hit       = 1'b1;
      r.new_count = nl[CNT_W-1:0];
    end else begin
      lim = (sh_limit == 0) ? 1 : sh_limit;
      if (lim > CAPACITY) lim = CAPACITY;
      if (sh_occ[g] >= lim) begin
        lo  = sh_lowest[g];
        len = (lo < LEVELS) ? sh_len[g][lo] : 0;
        if (len != 0) begin
          v = member_of(g, lo, len - 1);
          if (v >= 0) begin
            r.evicted     = 1'b1;
            r.evicted_key = sh_key[g][v];
            sh_valid[g][v] = 1'b0;
            sh_key[g][v]   = '0;
            sh_level[g][v] = 0;
            sh_pos[g][v]   = 0;
            sh_len[g][lo]  = len - 1;
            if (sh_occ[g] > 0) sh_occ[g]--;
          end
        end
      end
      fr = -1;
      for (int s = 0; s < CAPACITY; s++)
        if (fr < 0 && !sh_valid[g][s]) fr = s;
      if (fr >= 0) begin
        sh_valid[g][fr] = 1'b1;
        sh_key[g][fr]   = k;
        link_entry(g, fr, 1);
        sh_occ[g]++;
        sh_lowest[g] = 1;
        r.new_count  = CNT_W'(1);
      end
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stall, plus a long hold-off when asked for.
  always @(posedge clk)
    out_stall <= receiver_hold || ($urandom_range(99) < receiver_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        fail_count++;
      end else begin
        result_t e;
        e = expected_counts.pop_front();
        if (out_hit !== e.hit || out_new_count !== e.new_count ||
            out_evicted !== e.evicted || out_evicted_key !== e.evicted_key ||
            out_dropped !== e.dropped) begin
          $display("%0t: mismatch expected hit=%0d count=%0d ev=%0d evkey=%h drop=%0d",
                   $time, e.hit, e.new_count, e.evicted, e.evicted_key, e.dropped);
          $display("%0t:          actual hit=%0d count=%0d ev=%0d evkey=%h drop=%0d",
                   $time, out_hit, out_new_count, out_evicted, out_evicted_key,
                   out_dropped);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lfu_frequency_table_tb NOT OK");
      $finish;
    end
  end

  task automatic send_item(logic [GROUP_W-1:0] grp, logic [KEY_W-1:0] k);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_group    <= grp;
    in_item_key <= k;
    do @(posedge clk); while (in_stall);
    expected_counts = {expected_counts, count_item(grp, k)};
  endtask

  task automatic write_limit(logic [LIM_W-1:0] v);
    in_valid <= 1'b0;
    wait (expected_counts.size() == 0);
    repeat (IDLE_GAP) @(posedge clk);
    cfg_valid           <= 1'b1;
    cfg_occupancy_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sh_limit = v;
  endtask

  stim_row_t directed_rows[$];
  logic [KEY_W-1:0] key_pool[12];
  int block_limits[6] = '{1, 3, 5, 127, 64, 0};

  initial begin
    stim_row_t row;
    result_t   got;
    logic [GROUP_W-1:0] grp;
    logic [KEY_W-1:0]   k;
    int sel;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_group = '0;
    in_item_key = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_occupancy_limit = '0;
    receiver_hold = 1'b0;
    receiver_stall_pct = 0;
    sender_idle_pct = 0;
    quiet_cycles = 0;
    fail_count = 0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int s = 0; s < CAPACITY; s++) begin
        sh_key[g][s] = '0; sh_valid[g][s] = 1'b0; sh_level[g][s] = 0; sh_pos[g][s] = 0;
      end
      for (int l = 0; l < LEVELS; l++) sh_len[g][l] = 0;
      sh_lowest[g] = 1;
      sh_occ[g] = 0;
    end
    sh_limit = LIMIT_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: out-of-range groups, extreme keys and groups, a first hit.
    row = '{grp: 8'd16,  k: '0, typed: 1, res: '{0, 8'd0, 0, 64'd0, 1}};
    directed_rows = {directed_rows, row};
    row = '{grp: 8'd255, k: '1, typed: 1, res: '{0, 8'd0, 0, 64'd0, 1}};
    directed_rows = {directed_rows, row};
    row = '{grp: 8'd0,  k: '0, typed: 1, res: '{0, 8'd1, 0, 64'd0, 0}};
    directed_rows = {directed_rows, row};
    row = '{grp: 8'd0,  k: '0, typed: 1, res: '{1, 8'd2, 0, 64'd0, 0}};
    directed_rows = {directed_rows, row};
    row = '{grp: 8'd15, k: '1, typed: 1, res: '{0, 8'd1, 0, 64'd0, 0}};
    directed_rows = {directed_rows, row};
    row = '{grp: 8'd15, k: '1, typed: 1, res: '{1, 8'd2, 0, 64'd0, 0}};
    directed_rows = {directed_rows, row};
    row = '{grp: 8'd15, k: 64'h5555_5555_5555_5555, typed: 0, res: '0};
    directed_rows = {directed_rows, row};
    row = '{grp: 8'd15, k: 64'hAAAA_AAAA_AAAA_AAAA, typed: 0, res: '0};
    directed_rows = {directed_rows, row};
    row = '{grp: 8'd15, k: 64'h5555_5555_5555_5555, typed: 0, res: '0};
    directed_rows = {directed_rows, row};
    row = '{grp: 8'd0,  k: '1, typed: 0, res: '0};
    directed_rows = {directed_rows, row};
    row = '{grp: 8'd0,  k: '0, typed: 0, res: '0};
    directed_rows = {directed_rows, row};
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].grp, directed_rows[i].k);
      if (directed_rows[i].typed) begin
        got = expected_counts[expected_counts.size() - 1];
        if (got != directed_rows[i].res) begin
          $display("%0t: table row %0d expected %h, predicted %h",
                   $time, i, directed_rows[i].res, got);
          fail_count++;
        end
      end
    end

    for (int b = 0; b < 6; b++) begin
      write_limit(block_limits[b][LIM_W-1:0]);
      sender_idle_pct    = (b < 2) ? 14 : (b < 4) ? 77 : 0;
      receiver_stall_pct = (b < 2) ? 77 : (b < 4) ? 14 : 0;
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      if (b == 1)
        fork
          begin
            receiver_hold = 1'b1;
            repeat (600) @(posedge clk);
            receiver_hold = 1'b0;
          end
        join_none
      for (int n = 0; n < 170; n++) begin
        sel = $urandom_range(99);
        grp = ($urandom_range(4) == 0) ? GROUP_W'($urandom_range(NUM_GROUPS - 1)) :
                                         GROUP_W'($urandom_range(3));
        if (sel < 60) begin
          k = key_pool[$urandom_range(11)];
        end else begin
          k = {$urandom, $urandom};
          // Fresh keys pile into one group so that a full-size group evicts.
          if (block_limits[b] >= CAPACITY) grp = GROUP_W'(2);
        end
        if (sel >= 90) grp = GROUP_W'($urandom_range(255, NUM_GROUPS));
        send_item(grp, k);
      end
    end

    // One key driven to the top level and held there.
    k = {$urandom, $urandom};
    for (int n = 0; n < LEVELS + 4; n++) send_item(8'd9, k);
    in_valid <= 1'b0;

    wait (expected_counts.size() == 0);
    repeat (IDLE_GAP) @(posedge clk);
    if (fail_count == 0)
      $display("lfu_frequency_table_tb OK");
    else
      $display("lfu_frequency_table_tb NOT OK");
    $finish;
  end

endmodule

### files.f
rtl/core/lfu_pkg.sv
rtl/core/lfu_ram.sv
rtl/core/lfu_seq.sv
rtl/core/lfu_frequency_table.sv
tb/lfu_frequency_table_tb.sv
